/* hw/rtl/smfm_pkg.sv */
// Shared types and constants of the sorted frequency mask merger.
package smfm_pkg;

  // Default frequency width in bits
  localparam int unsigned FREQ_BITS_DEF = 36;
  // Default depth of the queue between front and back (power of two)
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  // Width of the half-width register and its value after reset
  localparam int unsigned HALF_BITS = 24;
  localparam logic [HALF_BITS-1:0] HALF_RESET = 24'd50;

  // Result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ORDER = 1'b1;

  // Control part of one queued request
  typedef struct packed {
    logic is_err;   // out-of-order frequency, emit an error result only
    logic g_final;  // first result closes the run
    logic two_res;  // a single-point group at p_freq follows as final result
  } ctl_t;

endpackage

/* hw/rtl/smfm_front.sv */
// Front end: accepts frequencies, tracks the open group and queues emit requests.
module smfm_front #(
  parameter int unsigned FREQ_BITS = smfm_pkg::FREQ_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [FREQ_BITS-1:0]           freq_i,
  input  logic                           run_end_i,
  input  logic [smfm_pkg::HALF_BITS-1:0] half_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output smfm_pkg::ctl_t                 ctl_o,
  output logic [FREQ_BITS-1:0]           g_first_o,
  output logic [FREQ_BITS-1:0]           g_last_o,
  output logic [FREQ_BITS-1:0]           p_freq_o
);

  localparam int unsigned SW =
    ((FREQ_BITS > smfm_pkg::HALF_BITS + 1) ? FREQ_BITS : smfm_pkg::HALF_BITS + 1) + 1;

  logic                 open_q, open_d;
  logic [FREQ_BITS-1:0] first_q, first_d;
  logic [FREQ_BITS-1:0] prev_q, prev_d;
  logic                 accept;
  logic [SW-1:0]        limit;
  logic [SW-1:0]        freq_ext;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  // Join limit: previous frequency plus two half-widths
  assign freq_ext = {{(SW-FREQ_BITS){1'b0}}, freq_i};
  assign limit    = {{(SW-FREQ_BITS){1'b0}}, prev_q}
                  + {{(SW-smfm_pkg::HALF_BITS-1){1'b0}}, half_i, 1'b0};

  // Classify the item and form the emit request
  always_comb begin
    open_d    = open_q;
    first_d   = first_q;
    prev_d    = prev_q;
    push_o    = 1'b0;
    ctl_o     = '0;
    g_first_o = first_q;
    g_last_o  = prev_q;
    p_freq_o  = freq_i;
    if (accept) begin
      if (!open_q) begin
        // open a new group
        first_d   = freq_i;
        prev_d    = freq_i;
        open_d    = ~run_end_i;
        push_o    = run_end_i;
        g_first_o = freq_i;
        g_last_o  = freq_i;
        ctl_o.g_final = 1'b1;
      end else if (freq_i < prev_q) begin
        // abort the run on out-of-order frequency
        open_d       = 1'b0;
        first_d      = '0;
        prev_d       = '0;
        push_o       = 1'b1;
        ctl_o.is_err = 1'b1;
        ctl_o.g_final = 1'b1;
      end else if (freq_ext > limit) begin
        // close the open group and start a new one here
        first_d       = freq_i;
        prev_d        = freq_i;
        open_d        = ~run_end_i;
        push_o        = 1'b1;
        ctl_o.two_res = run_end_i;
      end else begin
        // extend the open group
        prev_d        = freq_i;
        open_d        = ~run_end_i;
        push_o        = run_end_i;
        g_last_o      = freq_i;
        ctl_o.g_final = 1'b1;
      end
    end
  end

  // Hold group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      first_q <= '0;
      prev_q  <= '0;
    end else begin
      open_q  <= open_d;
      first_q <= first_d;
      prev_q  <= prev_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_err_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && ctl_o.is_err) |-> (ctl_o.g_final && !ctl_o.two_res && !open_d))
    else $error("error request must be a single final result");
  a_final_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && (ctl_o.g_final || ctl_o.two_res)) |=> !open_q)
    else $error("group still open after final request");
`endif

endmodule

/* hw/rtl/smfm_queue.sv */
// Small register queue that decouples the front end from the result stage.
module smfm_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = smfm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Write the entry at the tail
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
`endif

endmodule

/* hw/rtl/smfm_back.sv */
// Result stage: expands queued requests into mask intervals in an output register.
module smfm_back #(
  parameter int unsigned FREQ_BITS = smfm_pkg::FREQ_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  output logic                           q_pop_o,
  input  smfm_pkg::ctl_t                 ctl_i,
  input  logic [FREQ_BITS-1:0]           g_first_i,
  input  logic [FREQ_BITS-1:0]           g_last_i,
  input  logic [FREQ_BITS-1:0]           p_freq_i,
  input  logic [smfm_pkg::HALF_BITS-1:0] half_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [FREQ_BITS:0]             center_x2_o,
  output logic [FREQ_BITS:0]             width_o,
  output logic                           status_o,
  output logic                           final_o
);

  localparam int unsigned OW = FREQ_BITS + 1;
  localparam int unsigned WW =
    ((OW > smfm_pkg::HALF_BITS + 1) ? OW : smfm_pkg::HALF_BITS + 1) + 1;

  logic              out_valid_q;
  logic [OW-1:0]     center_q, width_q;
  logic              status_q, final_q;
  logic              second_q;
  logic              load, take;
  logic [FREQ_BITS-1:0] lo_f, hi_f;
  logic [OW-1:0]     center_d;
  logic [WW-1:0]     width_full;
  logic [OW-1:0]     width_d;

  assign load = ~out_valid_q | out_ready_i;
  assign take = load & ~q_empty_i;
  assign q_pop_o = take & (second_q | ctl_i.is_err | ~ctl_i.two_res);

  // Select the group bounds of the result being built
  assign lo_f = second_q ? p_freq_i : g_first_i;
  assign hi_f = second_q ? p_freq_i : g_last_i;

  // Center times two and width with margins
  assign center_d   = {1'b0, lo_f} + {1'b0, hi_f};
  assign width_full = {{(WW-FREQ_BITS){1'b0}}, hi_f - lo_f}
                    + {{(WW-smfm_pkg::HALF_BITS-1){1'b0}}, half_i, 1'b0};
  assign width_d    = width_full[OW-1:0];

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (ctl_i.is_err && !second_q) begin
        center_q <= '0;
        width_q  <= '0;
        status_q <= smfm_pkg::STATUS_ORDER;
        final_q  <= 1'b1;
      end else begin
        center_q <= center_d;
        width_q  <= width_d;
        status_q <= smfm_pkg::STATUS_OK;
        final_q  <= second_q | ctl_i.g_final;
      end
    end
  end

  // Track output valid and the second result of a split-and-close request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      if (load) out_valid_q <= ~q_empty_i;
      if (take) second_q <= ~second_q & ~ctl_i.is_err & ctl_i.two_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign center_x2_o = center_q;
  assign width_o     = width_q;
  assign status_o    = status_q;
  assign final_o     = final_q;

`ifndef NO_ASSERTIONS
  a_second_has_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> (!q_empty_i && ctl_i.two_res && !ctl_i.is_err))
    else $error("second result pending without its request");
  a_first_not_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(second_q) |-> (out_valid_q && !final_q))
    else $error("first half of split request marked final");
`endif

endmodule

/* hw/rtl/sorted_frequency_mask_merger.sv */
// Top level of the sorted frequency mask merger.
// Usage:
//   s_axis carries ascending frequencies (tdata) with tlast marking the end
//   of a run. m_axis returns mask intervals: tdata holds center_x2 and width,
//   tuser the status (out-of-order error), tlast the final result of a run.
//   cfg writes min_half_width; write it only while the block is idle.
// Timing:
//   An item is classified in the cycle it is accepted and its request enters
//   a queue of QUEUE_DEPTH entries (four by default); from the queue head its
//   first result is loaded into the m_axis output register once it is free.
//   One item is accepted every cycle while the queue has room; the result stage
//   drives one result per cycle while m_axis accepts, two for a split at run end.
// Reset:
//   No group is open, the queue and output are empty, min_half_width is 50.
// Backpressure:
//   A stalled m_axis holds its result; the queue absorbs up to QUEUE_DEPTH
//   requests (four by default) before s_axis_tready drops.
module sorted_frequency_mask_merger #(
  parameter int unsigned FREQ_BITS   = smfm_pkg::FREQ_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = smfm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  logic [((FREQ_BITS+7)/8)*8-1:0]             s_axis_tdata,  // freq
  input  logic                                       s_axis_tlast,  // run_end
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  output logic [((2*(FREQ_BITS+1)+7)/8)*8-1:0]       m_axis_tdata,  // center_x2, width
  output logic                                       m_axis_tuser,  // status
  output logic                                       m_axis_tlast,  // final_element
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [smfm_pkg::HALF_BITS-1:0]             cfg_data_i     // min_half_width
);

  localparam int unsigned OW    = FREQ_BITS + 1;
  localparam int unsigned OUT_W = ((2*OW + 7) / 8) * 8;
  localparam int unsigned CTL_W = $bits(smfm_pkg::ctl_t);
  localparam int unsigned EW    = CTL_W + 3*FREQ_BITS;

  logic [smfm_pkg::HALF_BITS-1:0] half_q;
  logic                 push, pop, q_full, q_empty;
  smfm_pkg::ctl_t       f_ctl, b_ctl;
  logic [FREQ_BITS-1:0] f_first, f_last, f_p;
  logic [FREQ_BITS-1:0] b_first, b_last, b_p;
  logic [EW-1:0]        q_wdata, q_rdata;
  logic [OW-1:0]        center_x2, width;

  // Hold the half-width register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= smfm_pkg::HALF_RESET;
    end else if (cfg_valid_i) begin
      half_q <= cfg_data_i;
    end
  end

  smfm_front #(.FREQ_BITS(FREQ_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .freq_i     (s_axis_tdata[FREQ_BITS-1:0]),
    .run_end_i  (s_axis_tlast),
    .half_i     (half_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .ctl_o      (f_ctl),
    .g_first_o  (f_first),
    .g_last_o   (f_last),
    .p_freq_o   (f_p)
  );

  // Pack and unpack queue entries
  assign q_wdata = {f_ctl, f_first, f_last, f_p};
  assign {b_ctl, b_first, b_last, b_p} = q_rdata;

  smfm_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  smfm_back #(.FREQ_BITS(FREQ_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_pop_o     (pop),
    .ctl_i       (b_ctl),
    .g_first_i   (b_first),
    .g_last_i    (b_last),
    .p_freq_i    (b_p),
    .half_i      (half_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .center_x2_o (center_x2),
    .width_o     (width),
    .status_o    (m_axis_tuser),
    .final_o     (m_axis_tlast)
  );

  // Pack result fields, zero-fill to whole bytes
  assign m_axis_tdata[2*OW-1:0] = {width, center_x2};
  if (OUT_W > 2*OW) begin : g_pad
    assign m_axis_tdata[OUT_W-1:2*OW] = '0;
  end

endmodule

/* tb/tb_sorted_frequency_mask_merger.sv */
// Self-checking testbench for the sorted frequency mask merger: stream traffic, checks, watchdog.
module tb_sorted_frequency_mask_merger;

  localparam int unsigned FREQ_BITS = smfm_pkg::FREQ_BITS_DEF;
  localparam int unsigned HALF_BITS = smfm_pkg::HALF_BITS;
  localparam logic [HALF_BITS-1:0] HALF_RESET = smfm_pkg::HALF_RESET;
  localparam int unsigned OUT_BITS = FREQ_BITS + 1;
  localparam int unsigned TDATA_W = ((FREQ_BITS + 7) / 8) * 8;
  localparam int unsigned PAD_W = TDATA_W - FREQ_BITS;
  localparam int unsigned MDATA_W = ((2 * OUT_BITS + 7) / 8) * 8;
  localparam logic [FREQ_BITS-1:0] FREQ_MAX = '1;
  localparam logic [HALF_BITS-1:0] HALF_MAX = '1;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  // One mask element as it leaves the block
  typedef struct packed {
    logic [OUT_BITS-1:0] center_x2;
    logic [OUT_BITS-1:0] width;
    logic                status;
    logic                final_el;
  } mask_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata = '0;  // freq
  logic                 s_axis_tlast = 1'b0; // run_end
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [MDATA_W-1:0]   m_axis_tdata;       // center_x2, width
  logic                 m_axis_tuser;       // status
  logic                 m_axis_tlast;       // final_element
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [HALF_BITS-1:0] cfg_data = '0;      // min_half_width

  // Merge state mirrored from the block
  logic [HALF_BITS-1:0] half_width = HALF_RESET;
  logic [FREQ_BITS-1:0] grp_first = '0;
  logic [FREQ_BITS-1:0] grp_last = '0;
  bit                   grp_open = 1'b0;
  mask_t                pending_masks[$];

  bit src_idle = 1'b0;
  bit sink_idle = 1'b0;
  int sink_gap_left = 0;
  int sink_hold_left = 0;
  int stall_cycles = 0;

  int n_freqs_sent = 0;
  int n_runs = 0;
  int n_order_errors = 0;
  int n_masks_checked = 0;
  int n_half_settings = 0;
  int n_mismatches = 0;

  sorted_frequency_mask_merger dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int draw_gap(input bit idle_on);
    return idle_on ? int'($urandom_range(0, 16)) : 0;
  endfunction

  function automatic logic [FREQ_BITS-1:0] rand_freq();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[FREQ_BITS-1:0];
  endfunction

  // Append one expected mask element at the tail
  function automatic void queue_mask(input mask_t m);
    pending_masks.insert(pending_masks.size(), m);
  endfunction

  // Queue the mask element of the open group
  function automatic void push_group(input logic final_el);
    mask_t m;
    logic [63:0] c;
    logic [63:0] w;
    c = 64'(grp_first) + 64'(grp_last);
    w = 64'(grp_last - grp_first) + 64'(half_width) * 2;
    m.center_x2 = c[OUT_BITS-1:0];
    m.width = w[OUT_BITS-1:0];
    m.status = smfm_pkg::STATUS_OK;
    m.final_el = final_el;
    queue_mask(m);
  endfunction

  // Advance the merge state by one frequency and queue the masks it closes
  function automatic void predict_masks(input logic [FREQ_BITS-1:0] f, input logic last);
    mask_t m;
    logic [63:0] reach;
    reach = 64'(grp_last) + 64'(half_width) * 2;
    if (!grp_open) begin
      grp_first = f;
      grp_last = f;
      grp_open = 1'b1;
    end else if (f < grp_last) begin
      m = '0;
      m.status = smfm_pkg::STATUS_ORDER;
      m.final_el = 1'b1;
      queue_mask(m);
      grp_open = 1'b0;
      grp_first = '0;
      grp_last = '0;
      n_order_errors++;
      n_runs++;
      return;
    end else if (64'(f) > reach) begin
      push_group(1'b0);
      grp_first = f;
      grp_last = f;
    end else begin
      grp_last = f;
    end
    if (last) begin
      push_group(1'b1);
      grp_open = 1'b0;
      n_runs++;
    end
  endfunction

  // Offer one frequency and wait for the block to take it
  task automatic send_freq(input logic [FREQ_BITS-1:0] f, input logic last,
                           input logic [PAD_W-1:0] pad = '0);
    int gap;
    gap = draw_gap(src_idle);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {pad, f};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    predict_masks(f, last);
    n_freqs_sent++;
  endtask

  // Drop the request line and wait until every expected mask has arrived
  task automatic settle_idle(input int extra);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_half_width(input logic [HALF_BITS-1:0] v);
    settle_idle(SETTLE_CYCLES);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (cfg_ready !== 1'b1);
    half_width = v;
    n_half_settings++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // End an open group with a frequency that neither splits nor breaks it
  task automatic close_run();
    if (grp_open) send_freq(grp_last, 1'b1);
  endtask

  // Ascending run with random spacing around the merge distance, maybe one step back
  task automatic send_sorted_run(input int n_items, input bit with_break);
    logic [63:0] f;
    logic [63:0] span;
    logic [63:0] step;
    int brk_at;
    span = 64'(half_width) * 2;
    case ($urandom_range(0, 3))
      0: f = 64'($urandom_range(0, 2000));
      1: f = 64'(FREQ_MAX) - 64'($urandom_range(0, 2000));
      default: f = 64'(rand_freq());
    endcase
    brk_at = (with_break && n_items > 1) ? int'($urandom_range(1, n_items - 1)) : -1;
    for (int i = 0; i < n_items; i++) begin
      if (i > 0) begin
        case ($urandom_range(0, 9))
          0: step = 0;
          1, 2, 3: step = 64'($urandom_range(0, int'(span)));
          4: step = span;
          5: step = span + 1;
          6, 7: step = span + 1 + 64'($urandom_range(0, 5000));
          8: step = 64'($urandom);
          default: step = 64'(rand_freq());
        endcase
        f = f + step;
        if (f > 64'(FREQ_MAX)) f = 64'(FREQ_MAX);
      end
      if (i == brk_at && f != 0) begin
        if ($urandom_range(0, 1) == 0)
          f = {$urandom, $urandom} % f;
        else
          f = f - ((f > 1000) ? 64'($urandom_range(1, 1000)) : 64'($urandom_range(1, int'(f))));
        send_freq(f[FREQ_BITS-1:0], 1'($urandom_range(0, 1)));
        return;
      end
      send_freq(f[FREQ_BITS-1:0], i == n_items - 1);
    end
  endtask

  // Unsorted frequencies and random run ends
  task automatic send_noise(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 1) == 0)
        send_freq(rand_freq(), $urandom_range(0, 3) == 0);
      else
        send_freq(FREQ_BITS'($urandom_range(0, 500)), $urandom_range(0, 3) == 0);
    end
  endtask

  // Boundaries of the merge distance, range ends, two results at once, order breaks
  task automatic test_directed_edges();
    src_idle = 1'b1;
    sink_idle = 1'b1;
    send_freq('0, 1'b1);
    send_freq(FREQ_MAX, 1'b1);
    // exactly two half-widths joins, one more splits
    send_freq(36'd1000, 1'b0);
    send_freq(36'd1100, 1'b0);
    send_freq(36'd1201, 1'b0);
    send_freq(36'd1201, 1'b0);
    send_freq(36'd1301, 1'b1);
    // split and run end on the same item
    send_freq(36'd5000, 1'b0);
    send_freq(36'd5101, 1'b1);
    // step back with run end set, then a fresh run
    send_freq(36'd7000, 1'b0);
    send_freq(36'd6999, 1'b1);
    send_freq(36'd6999, 1'b1);
    send_freq(36'd8000, 1'b0);
    send_freq(36'd8100, 1'b0);
    send_freq('0, 1'b0);
    // full range in one run
    send_freq('0, 1'b0);
    send_freq(FREQ_MAX, 1'b1);
    // upper tdata padding must be ignored
    send_freq(36'd12345, 1'b1, '1);
    send_freq(FREQ_MAX - 36'd100, 1'b0);
    send_freq(FREQ_MAX, 1'b1);
  endtask

  task automatic test_half_width_extremes();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    // no margin: only equal frequencies merge
    write_half_width('0);
    send_freq(36'd10, 1'b0);
    send_freq(36'd10, 1'b0);
    send_freq(36'd11, 1'b1);
    send_freq(FREQ_MAX, 1'b1);
    write_half_width(HALF_MAX);
    send_freq('0, 1'b0);
    send_freq(FREQ_MAX, 1'b1);
    send_freq('0, 1'b0);
    send_freq(FREQ_BITS'(2 * 64'(HALF_MAX)), 1'b0);
    send_freq(FREQ_BITS'(4 * 64'(HALF_MAX) + 1), 1'b1);
    write_half_width(24'd1);
    send_freq(36'd100, 1'b0);
    send_freq(36'd102, 1'b0);
    send_freq(36'd105, 1'b1);
  endtask

  task automatic test_random_phase(input logic [HALF_BITS-1:0] hw, input int n_items);
    int target;
    int pick;
    write_half_width(hw);
    target = n_freqs_sent + n_items;
    while (n_freqs_sent < target) begin
      src_idle = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      pick = $urandom_range(0, 19);
      if (pick < 2)
        send_noise($urandom_range(1, 10));
      else if (pick < 4)
        send_sorted_run($urandom_range(2, 12), 1'b1);
      else if (pick < 6)
        send_sorted_run($urandom_range(20, 40), 1'b0);
      else
        send_sorted_run($urandom_range(1, 12), 1'b0);
      close_run();
    end
  endtask

  // Stall the output for a long stretch while runs keep coming, single items with a two-item run every fifth
  task automatic test_output_hold();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    sink_hold_left = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) begin
      if (i % 5 == 4)
        send_sorted_run(2, 1'b0);
      else
        send_freq(rand_freq(), 1'b1);
    end
    close_run();
  endtask

  task automatic flag_mismatch(input string what, input mask_t want, input mask_t got);
    n_mismatches++;
    if (n_mismatches <= 10) begin
      $display("mismatch %0d (%s): expected c2=%0d w=%0d st=%0b fin=%0b",
               n_mismatches, what, want.center_x2, want.width, want.status, want.final_el);
      $display("mismatch %0d (%s): got      c2=%0d w=%0d st=%0b fin=%0b",
               n_mismatches, what, got.center_x2, got.width, got.status, got.final_el);
    end
  endtask

  // Hold tready low for a requested stretch, else for the drawn gap
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold_left = sink_hold_left - 1;
    end else if (sink_gap_left > 0) begin
      m_axis_tready <= 1'b0;
      sink_gap_left = sink_gap_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each accepted mask with the oldest expected one
  always @(posedge clk_i) begin
    mask_t got;
    mask_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      got.center_x2 = m_axis_tdata[OUT_BITS-1:0];
      got.width = m_axis_tdata[2*OUT_BITS-1:OUT_BITS];
      got.status = m_axis_tuser;
      got.final_el = m_axis_tlast;
      if (pending_masks.size() == 0) begin
        flag_mismatch("nothing expected", '0, got);
      end else begin
        want = pending_masks.pop_front();
        if (got.center_x2 !== want.center_x2 || got.width !== want.width ||
            got.status !== want.status || got.final_el !== want.final_el)
          flag_mismatch("field", want, got);
      end
      n_masks_checked++;
      sink_gap_left = draw_gap(sink_idle);
    end
  end

  // Abort when no request moves on any channel for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request accepted for %0d cycles, %0d masks outstanding",
               stall_cycles, pending_masks.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_edges();
    test_half_width_extremes();
    test_random_phase(24'd1, 280);
    test_random_phase(HALF_MAX, 280);
    test_random_phase(HALF_RESET, 280);
    test_random_phase(HALF_BITS'($urandom_range(2, 200)), 280);
    test_random_phase(HALF_BITS'($urandom_range(201, 65535)), 280);
    test_random_phase(HALF_BITS'($urandom_range(0, 32'(HALF_MAX))), 280);
    test_output_hold();
    settle_idle(DRAIN_CYCLES);
    $display("sent %0d frequencies in %0d runs over %0d half-width settings",
             n_freqs_sent, n_runs, n_half_settings);
    $display("checked %0d mask results, %0d out-of-order aborts, %0d mismatches",
             n_masks_checked, n_order_errors, n_mismatches);
    if (n_mismatches == 0 && pending_masks.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/smfm_pkg.sv
hw/rtl/smfm_front.sv
hw/rtl/smfm_queue.sv
hw/rtl/smfm_back.sv
hw/rtl/sorted_frequency_mask_merger.sv
tb/tb_sorted_frequency_mask_merger.sv
